/* rtl/mcwd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel watchdog monitor.
// No dependencies; used by every module of the block except mcwd_ram.

package mcwd_pkg;

    // Request codes as they arrive in the request kind field.
    localparam logic [2:0] REQ_ADD_TIMEOUT = 3'd0;
    localparam logic [2:0] REQ_KICK        = 3'd1;
    localparam logic [2:0] REQ_ADD_RETRY   = 3'd2;
    localparam logic [2:0] REQ_RETRY_INC   = 3'd3;
    localparam logic [2:0] REQ_RETRY_CLR   = 3'd4;
    localparam logic [2:0] REQ_TICK        = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // Channel modes.
    localparam logic MODE_TIMEOUT = 1'b0;
    localparam logic MODE_RETRY   = 1'b1;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        OP_ADD_TIMEOUT,
        OP_KICK,
        OP_ADD_RETRY,
        OP_RETRY_INC,
        OP_RETRY_CLR,
        OP_TICK,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  channel;
        logic [31:0] limit;
    } t_cmd;

    // One channel table entry; value is the start time of a timeout channel
    // or the retry count of a retry channel.
    typedef struct packed {
        logic        mode;
        logic [31:0] limit;
        logic [31:0] value;
    } t_entry;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] new_channel;
        logic       reboot;
    } t_result;

endpackage

/* rtl/mcwd_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module mcwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/mcwd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them into operations and queues them.
// Depends on mcwd_pkg.

module mcwd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  logic [2:0]       i_req_type,
    input  logic [3:0]       i_channel,
    input  logic [31:0]      i_limit,
    output logic             o_cmd_valid,
    input  logic             i_cmd_ready,
    output mcwd_pkg::t_cmd   o_cmd
);

    localparam int PW = (mcwd_pkg::QDEPTH > 1) ? $clog2(mcwd_pkg::QDEPTH) : 1;
    localparam int NW = $clog2(mcwd_pkg::QDEPTH + 1);

    mcwd_pkg::t_cmd r_q [mcwd_pkg::QDEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [NW-1:0]  r_count;
    mcwd_pkg::t_cmd cmd_in;
    logic           push, pop;

    function automatic mcwd_pkg::t_op decode(input logic [2:0] req);
        mcwd_pkg::t_op op;
        case (req)
            mcwd_pkg::REQ_ADD_TIMEOUT: op = mcwd_pkg::OP_ADD_TIMEOUT;
            mcwd_pkg::REQ_KICK:        op = mcwd_pkg::OP_KICK;
            mcwd_pkg::REQ_ADD_RETRY:   op = mcwd_pkg::OP_ADD_RETRY;
            mcwd_pkg::REQ_RETRY_INC:   op = mcwd_pkg::OP_RETRY_INC;
            mcwd_pkg::REQ_RETRY_CLR:   op = mcwd_pkg::OP_RETRY_CLR;
            mcwd_pkg::REQ_TICK:        op = mcwd_pkg::OP_TICK;
            default:                   op = mcwd_pkg::OP_BAD;
        endcase
        return op;
    endfunction

    always_comb begin
        cmd_in.op      = decode(i_req_type);
        cmd_in.channel = i_channel;
        cmd_in.limit   = i_limit;
    end

    assign o_req_ready = (r_count != NW'(mcwd_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rptr];
    assign push        = i_req_valid && o_req_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(mcwd_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(mcwd_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/mcwd_back.sv */
`timescale 1ns / 1ps
// Back end: executes queued operations against the channel table RAM,
// keeps the time counter and fill count, and holds the result register.
// Depends on mcwd_pkg and mcwd_ram.

module mcwd_back #(
    parameter int CHANNELS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  mcwd_pkg::t_cmd    i_cmd,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mcwd_pkg::t_result o_out
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW = $clog2(CHANNELS + 1);
    localparam int IW = (CW > 4) ? CW : 4;
    localparam int EW = $bits(mcwd_pkg::t_entry);

    typedef enum logic [1:0] {S_IDLE, S_ACCESS, S_SCAN} t_state;

    t_state            r_state, n_state;
    logic [31:0]       r_now, n_now;
    logic [CW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_addr, n_addr;
    mcwd_pkg::t_op     r_op, n_op;
    logic              r_reboot, n_reboot;
    logic              r_out_valid, n_out_valid;
    mcwd_pkg::t_result r_out, n_out;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    mcwd_pkg::t_entry  wentry, rentry;
    logic [EW-1:0]     rdata;

    logic [IW-1:0]     ch_ext, used_ext;
    logic              take, out_free, is_full;
    logic              want_mode, wrapped, expired, scan_hit;
    logic [31:0]       elapsed, retry_next;

    mcwd_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rentry   = mcwd_pkg::t_entry'(rdata);
    assign ch_ext   = IW'(i_cmd.channel);
    assign used_ext = IW'(r_used);
    assign is_full  = (r_used == CW'(CHANNELS));
    assign out_free = !r_out_valid || i_out_ready;
    assign take     = (r_state == S_IDLE) && i_cmd_valid && out_free;

    assign o_cmd_ready = take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Per-entry tick check: restart on wrap, flag when elapsed exceeds limit.
    assign elapsed  = r_now - rentry.value;
    assign wrapped  = (rentry.mode == mcwd_pkg::MODE_TIMEOUT) && (r_now < rentry.value);
    assign expired  = (rentry.mode == mcwd_pkg::MODE_TIMEOUT) && !wrapped
                      && (elapsed > rentry.limit);
    assign scan_hit = r_reboot || expired;

    assign retry_next = (rentry.value == '1) ? rentry.value : rentry.value + 32'd1;
    assign want_mode  = (r_op == mcwd_pkg::OP_KICK) ? mcwd_pkg::MODE_TIMEOUT
                                                    : mcwd_pkg::MODE_RETRY;

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_used      = r_used;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_op        = r_op;
        n_reboot    = r_reboot;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = r_addr;
        raddr       = r_addr;
        wentry      = rentry;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_out = '{status: mcwd_pkg::ST_DONE, new_channel: 4'd0, reboot: 1'b0};
                    case (i_cmd.op)
                        mcwd_pkg::OP_ADD_TIMEOUT, mcwd_pkg::OP_ADD_RETRY: begin
                            n_out_valid = 1'b1;
                            if (is_full) begin
                                n_out.status = mcwd_pkg::ST_FULL;
                            end else begin
                                we           = 1'b1;
                                waddr        = r_used[AW-1:0];
                                wentry.limit = i_cmd.limit;
                                if (i_cmd.op == mcwd_pkg::OP_ADD_TIMEOUT) begin
                                    wentry.mode  = mcwd_pkg::MODE_TIMEOUT;
                                    wentry.value = r_now;
                                end else begin
                                    wentry.mode  = mcwd_pkg::MODE_RETRY;
                                    wentry.value = '0;
                                end
                                n_used            = r_used + 1'b1;
                                n_out.new_channel = used_ext[3:0];
                            end
                        end
                        mcwd_pkg::OP_KICK, mcwd_pkg::OP_RETRY_INC,
                        mcwd_pkg::OP_RETRY_CLR: begin
                            if (ch_ext < used_ext) begin
                                re      = 1'b1;
                                raddr   = ch_ext[AW-1:0];
                                n_addr  = ch_ext[AW-1:0];
                                n_op    = i_cmd.op;
                                n_state = S_ACCESS;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out.status = mcwd_pkg::ST_IGNORED;
                            end
                        end
                        mcwd_pkg::OP_TICK: begin
                            // Advance time first; the scan sees the new value.
                            n_now = r_now + 32'd1;
                            if (r_used == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                re       = 1'b1;
                                raddr    = '0;
                                n_addr   = '0;
                                n_idx    = CW'(1);
                                n_reboot = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out.status = mcwd_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
                if (rentry.mode != want_mode) begin
                    n_out.status = mcwd_pkg::ST_IGNORED;
                end else begin
                    we = 1'b1;
                    case (r_op)
                        mcwd_pkg::OP_KICK: wentry.value = r_now;
                        mcwd_pkg::OP_RETRY_INC: begin
                            wentry.value = retry_next;
                            n_out.reboot = (retry_next >= rentry.limit);
                        end
                        default: wentry.value = '0;
                    endcase
                end
            end
            S_SCAN: begin
                if (wrapped) begin
                    we           = 1'b1;
                    wentry.value = r_now;
                end
                if (r_idx == r_used) begin
                    n_out_valid  = 1'b1;
                    n_out.reboot = scan_hit;
                    n_state      = S_IDLE;
                end else begin
                    re       = 1'b1;
                    raddr    = r_idx[AW-1:0];
                    n_addr   = r_idx[AW-1:0];
                    n_idx    = r_idx + 1'b1;
                    n_reboot = scan_hit;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_op     <= n_op;
        r_reboot <= n_reboot;
        r_out    <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/multi_channel_watchdog_monitor.sv */
`timescale 1ns / 1ps
// Multi-channel watchdog monitor, top level.
// Depends on mcwd_pkg, mcwd_front, mcwd_back (and mcwd_ram through it).

// Each request on the slave stream gives exactly one result on the master
// stream, in order. Channels are allocated in order from index 0 and never
// freed; a timeout channel is restarted by a kick, a retry channel counts
// increments against its limit. A request is decoded combinationally into a
// two-entry command queue, so the input can take up to two requests while a
// result waits. The back end answers an add, an unknown request or a request
// to an unallocated channel straight from idle; a kick, retry increment or
// retry clear goes through a table read, then an update; a tick reads every
// allocated channel through the table's single read port, one per cycle, and
// the back end takes no new request until that scan is done.
// The channel table needs no clearing after reset; only allocated entries are
// ever read.

module multi_channel_watchdog_monitor #(
    parameter int CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [3:0] channel, [35:4] limit, [39:36] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] req_type
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [3:0] new_channel, [4] reboot, [7:5] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic              cmd_valid, cmd_ready;
    mcwd_pkg::t_cmd    cmd;
    mcwd_pkg::t_result result;

    // Classify requests and hold them in the queue.
    mcwd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req_type  (i_s_tuser),
        .i_channel   (i_s_tdata[3:0]),
        .i_limit     (i_s_tdata[35:4]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Execute against the table and register the result.
    mcwd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out       (result)
    );

    // Pack the result; pad bits stay zero.
    assign o_m_tdata = {3'b000, result.reboot, result.new_channel};
    assign o_m_tuser = result.status;

endmodule

/* rtl/mcwd_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the watchdog monitor, bound to the top level.
// Depends on mcwd_pkg and multi_channel_watchdog_monitor.

module mcwd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Reset empties the queue and the result register.
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_s_tready && !o_m_tvalid)
        else $error("block not empty after reset");

    // Only the three defined status codes appear.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == mcwd_pkg::ST_DONE || o_m_tuser == mcwd_pkg::ST_FULL
                       || o_m_tuser == mcwd_pkg::ST_IGNORED)
        else $error("undefined status code");

    // A full or ignored request carries no channel and no reboot.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != mcwd_pkg::ST_DONE |-> o_m_tdata == 8'd0)
        else $error("failed request carries data");

endmodule

bind multi_channel_watchdog_monitor mcwd_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
